// File: src/bar_pkg.sv
// ----------------------------------------------------------------------------
// bar_pkg
// Shared types, register codes and the arctangent table for the bearing,
// alignment and range unit.
// ----------------------------------------------------------------------------
package bar_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int POS_WIDTH_DEF    = 16;
   localparam int FRAC_BITS        = 16;
   localparam int ATAN_LEN         = 24;
   localparam int ANGLE_W          = 32;
   localparam int CSR_IDX_W        = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_X  = 2'd0,
      CSR_TARGET_Y  = 2'd1,
      CSR_TOLERANCE = 2'd2
   } csr_index_type;

   localparam logic [15:0] TOLERANCE_RESET = 16'd364;

   // round(atan(2^-i) * 2^32 / (2*pi))
   localparam logic [ANGLE_W-1:0] ATAN_TURNS [ATAN_LEN] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10680862,  32'd5340757,
      32'd2670675,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   typedef struct packed {
      logic [15:0] heading;
      logic        zero;
   } bar_side_type;

   typedef struct packed {
      logic               aligned;
      logic signed [15:0] heading_error;
      logic [15:0]        distance_mm;
   } bar_result_type;

   function automatic int bar_max(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

// File: src/bar_if.sv
// ----------------------------------------------------------------------------
// bar_if
// Valid/ready channels of the bearing unit: pose requests, results and
// register writes.
// ----------------------------------------------------------------------------
interface bar_req_if #(parameter int POS_W = 16);
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] robot_x;
   logic signed [POS_W-1:0] robot_y;
   logic signed [15:0]      robot_heading;

   modport source (output valid, robot_x, robot_y, robot_heading, input ready);
   modport sink   (input valid, robot_x, robot_y, robot_heading, output ready);
endinterface

interface bar_rsp_if;
   logic               valid;
   logic               ready;
   logic               aligned;
   logic signed [15:0] heading_error;
   logic [15:0]        distance_mm;

   modport source (output valid, aligned, heading_error, distance_mm, input ready);
   modport sink   (input valid, aligned, heading_error, distance_mm, output ready);
endinterface

interface bar_csr_if #(parameter int DATA_W = 16);
   import bar_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DATA_W-1:0]    wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// File: src/bearing_alignment_and_range_unit.sv
// ----------------------------------------------------------------------------
// bearing_alignment_and_range_unit
// Bearing to a configured target by vectoring CORDIC, wrapped heading error,
// alignment flag and rounded Euclidean distance from a pose request.
// ----------------------------------------------------------------------------
// Path: offsets, start vector and squares, radicand, the step chain, output register.
// Throughput: one request per cycle while the skid entry is empty; CORDIC iteration k
// and root digit k share pipeline stage k, so the longer of the two chains sets latency.
// An output register plus one skid entry lets a request enter while a result waits.
// Synchronous reset clears all valid bits, empties the output and sets target
// to (0, 0) and tolerance to 364.
module bearing_alignment_and_range_unit #(
   parameter int CORDIC_STEPS = bar_pkg::CORDIC_STEPS_DEF,
   parameter int POS_WIDTH    = bar_pkg::POS_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   bar_req_if.sink       req_ch,
   bar_rsp_if.source     rsp_ch,
   bar_csr_if.sink       csr_ch
);
   import bar_pkg::*;

   localparam int POS_W  = POS_WIDTH;
   localparam int DX_W   = POS_W + 1;
   localparam int SQ_W   = 2 * POS_W + 1;
   localparam int ROOT_W = POS_W + 2;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 2;
   localparam int CORD_W = POS_W + FRAC_BITS + 3;
   localparam int DEPTH  = bar_max(CORDIC_STEPS, ROOT_W);
   localparam int DIST_W = bar_max(ROOT_W, 16);

   // ------------------------------------------------------------------
   // registers
   logic signed [POS_W-1:0] tx_ff;
   logic signed [POS_W-1:0] ty_ff;
   logic [15:0]             tol_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_ff  <= '0;
         ty_ff  <= '0;
         tol_ff <= TOLERANCE_RESET;
      end else if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_TARGET_X:  tx_ff  <= csr_ch.wdata[POS_W-1:0];
            CSR_TARGET_Y:  ty_ff  <= csr_ch.wdata[POS_W-1:0];
            CSR_TOLERANCE: tol_ff <= csr_ch.wdata[15:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // pipeline enable: the whole pipe moves unless the skid entry is full
   logic skid_v_ff;
   logic en;

   assign en           = !skid_v_ff;
   assign req_ch.ready = en;

   // stage A: offsets
   logic                   a_v_ff;
   logic signed [DX_W-1:0] a_dx_ff, a_dx_in;
   logic signed [DX_W-1:0] a_dy_ff, a_dy_in;
   bar_side_type           a_side_ff, a_side_in;

   assign a_dx_in           = DX_W'(tx_ff) - DX_W'(req_ch.robot_x);
   assign a_dy_in           = DX_W'(ty_ff) - DX_W'(req_ch.robot_y);
   assign a_side_in.heading = req_ch.robot_heading;
   assign a_side_in.zero    = (tx_ff == req_ch.robot_x) && (ty_ff == req_ch.robot_y);

   // stage B: CORDIC start vector and squares
   logic                     b_v_ff;
   logic signed [CORD_W-1:0] b_x_ff, b_x_in;
   logic signed [CORD_W-1:0] b_y_ff, b_y_in;
   logic [31:0]              b_acc_ff, b_acc_in;
   logic [SQ_W-1:0]          b_sqx_ff, b_sqx_in;
   logic [SQ_W-1:0]          b_sqy_ff, b_sqy_in;
   bar_side_type             b_side_ff;

   logic signed [CORD_W-1:0] dx_w, dy_w, sx, sy;
   logic signed [2*DX_W-1:0] sqx_full, sqy_full;
   logic                     left_half;

   assign left_half = a_dx_ff[DX_W-1];
   assign dx_w      = CORD_W'(a_dx_ff);
   assign dy_w      = CORD_W'(a_dy_ff);
   // left half plane: start half a turn around with the vector negated
   assign sx        = left_half ? -dx_w : dx_w;
   assign sy        = left_half ? -dy_w : dy_w;
   assign b_x_in    = sx <<< FRAC_BITS;
   assign b_y_in    = sy <<< FRAC_BITS;
   assign b_acc_in  = left_half ? 32'h8000_0000 : 32'h0000_0000;
   assign sqx_full  = a_dx_ff * a_dx_ff;
   assign sqy_full  = a_dy_ff * a_dy_ff;
   assign b_sqx_in  = sqx_full[SQ_W-1:0];
   assign b_sqy_in  = sqy_full[SQ_W-1:0];

   // stage C: radicand = 4 * (dx^2 + dy^2) so the root carries a half bit
   logic                     c_v_ff;
   logic signed [CORD_W-1:0] c_x_ff;
   logic signed [CORD_W-1:0] c_y_ff;
   logic [31:0]              c_acc_ff;
   logic [RAD_W-1:0]         c_rad_ff, c_rad_in;
   bar_side_type             c_side_ff;
   logic [SQ_W:0]            sq_sum;

   assign sq_sum   = (SQ_W+1)'(b_sqx_ff) + (SQ_W+1)'(b_sqy_ff);
   assign c_rad_in = {sq_sum, 2'b00};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= req_ch.valid;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_dx_ff   <= a_dx_in;
         a_dy_ff   <= a_dy_in;
         a_side_ff <= a_side_in;
         b_x_ff    <= b_x_in;
         b_y_ff    <= b_y_in;
         b_acc_ff  <= b_acc_in;
         b_sqx_ff  <= b_sqx_in;
         b_sqy_ff  <= b_sqy_in;
         b_side_ff <= a_side_ff;
         c_x_ff    <= b_x_ff;
         c_y_ff    <= b_y_ff;
         c_acc_ff  <= b_acc_ff;
         c_rad_ff  <= c_rad_in;
         c_side_ff <= b_side_ff;
      end
   end

   // ------------------------------------------------------------------
   // iteration chain
   logic                     ch_v    [DEPTH+1];
   logic signed [CORD_W-1:0] ch_x    [DEPTH+1];
   logic signed [CORD_W-1:0] ch_y    [DEPTH+1];
   logic [31:0]              ch_acc  [DEPTH+1];
   logic [RAD_W-1:0]         ch_rad  [DEPTH+1];
   logic [REM_W-1:0]         ch_rem  [DEPTH+1];
   logic [ROOT_W-1:0]        ch_root [DEPTH+1];
   bar_side_type             ch_side [DEPTH+1];

   assign ch_v[0]    = c_v_ff;
   assign ch_x[0]    = c_x_ff;
   assign ch_y[0]    = c_y_ff;
   assign ch_acc[0]  = c_acc_ff;
   assign ch_rad[0]  = c_rad_ff;
   assign ch_rem[0]  = '0;
   assign ch_root[0] = '0;
   assign ch_side[0] = c_side_ff;

   generate
      for (genvar k = 0; k < DEPTH; k++) begin : g_step
         bar_step #(
            .STEP         (k),
            .CORDIC_STEPS (CORDIC_STEPS),
            .ROOT_W       (ROOT_W),
            .CORD_W       (CORD_W)
         ) u_step (
            .clock    (clock),
            .reset    (reset),
            .en       (en),
            .up_valid (ch_v[k]),
            .up_x     (ch_x[k]),
            .up_y     (ch_y[k]),
            .up_acc   (ch_acc[k]),
            .up_rad   (ch_rad[k]),
            .up_rem   (ch_rem[k]),
            .up_root  (ch_root[k]),
            .up_side  (ch_side[k]),
            .dn_valid (ch_v[k+1]),
            .dn_x     (ch_x[k+1]),
            .dn_y     (ch_y[k+1]),
            .dn_acc   (ch_acc[k+1]),
            .dn_rad   (ch_rad[k+1]),
            .dn_rem   (ch_rem[k+1]),
            .dn_root  (ch_root[k+1]),
            .dn_side  (ch_side[k+1])
         );
      end
   endgenerate

   // ------------------------------------------------------------------
   // finish: bearing rounding, wrapped error, alignment, distance
   logic [31:0]       bear_sum;
   logic [15:0]       bearing;
   logic [15:0]       err;
   logic [15:0]       aerr;
   logic [ROOT_W:0]   root_p1;
   logic [DIST_W-1:0] dist_w;
   bar_result_type    fin;

   assign bear_sum = ch_acc[DEPTH] + 32'h0000_8000;
   assign bearing  = ch_side[DEPTH].zero ? 16'h0000 : bear_sum[31:16];
   assign err      = ch_side[DEPTH].heading - bearing;
   assign root_p1  = {1'b0, ch_root[DEPTH]} + (ROOT_W+1)'(1);
   assign dist_w   = DIST_W'(root_p1[ROOT_W:1]);

   always_comb begin
      // half a turn has no positive twin
      if (err == 16'h8000) begin
         aerr = 16'h7FFF;
      end else if (err[15]) begin
         aerr = -err;
      end else begin
         aerr = err;
      end
      fin.aligned       = (aerr < tol_ff);
      fin.heading_error = err;
      fin.distance_mm   = (dist_w > DIST_W'(16'hFFFF)) ? 16'hFFFF : dist_w[15:0];
   end

   // ------------------------------------------------------------------
   // output register and skid entry
   logic           out_v_ff, out_v_in;
   logic           skid_v_in;
   bar_result_type out_ff, out_in;
   bar_result_type skid_ff, skid_in;

   always_comb begin
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (en) begin
         if (!out_v_ff || rsp_ch.ready) begin
            out_v_in = ch_v[DEPTH];
            out_in   = fin;
         end else if (ch_v[DEPTH]) begin
            skid_v_in = 1'b1;
            skid_in   = fin;
         end
      end else if (rsp_ch.ready) begin
         out_v_in  = 1'b1;
         out_in    = skid_ff;
         skid_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_ch.valid         = out_v_ff;
   assign rsp_ch.aligned       = out_ff.aligned;
   assign rsp_ch.heading_error = out_ff.heading_error;
   assign rsp_ch.distance_mm   = out_ff.distance_mm;

endmodule

// File: src/bar_step.sv
// ----------------------------------------------------------------------------
// bar_step
// One pipeline stage: one vectoring CORDIC iteration and one digit of the
// restoring square root, both registered; a chain past its last step passes through.
// ----------------------------------------------------------------------------
module bar_step #(
   parameter int STEP         = 0,
   parameter int CORDIC_STEPS = 16,
   parameter int ROOT_W       = 18,
   parameter int CORD_W       = 35
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      up_valid,
   input  logic signed [CORD_W-1:0]  up_x,
   input  logic signed [CORD_W-1:0]  up_y,
   input  logic [31:0]               up_acc,
   input  logic [2*ROOT_W-1:0]       up_rad,
   input  logic [ROOT_W+1:0]         up_rem,
   input  logic [ROOT_W-1:0]         up_root,
   input  bar_pkg::bar_side_type     up_side,
   output logic                      dn_valid,
   output logic signed [CORD_W-1:0]  dn_x,
   output logic signed [CORD_W-1:0]  dn_y,
   output logic [31:0]               dn_acc,
   output logic [2*ROOT_W-1:0]       dn_rad,
   output logic [ROOT_W+1:0]         dn_rem,
   output logic [ROOT_W-1:0]         dn_root,
   output bar_pkg::bar_side_type     dn_side
);
   import bar_pkg::*;

   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 2;

   logic                     valid_ff;
   logic signed [CORD_W-1:0] x_ff, x_in;
   logic signed [CORD_W-1:0] y_ff, y_in;
   logic [31:0]              acc_ff, acc_in;
   logic [RAD_W-1:0]         rad_ff, rad_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [ROOT_W-1:0]        root_ff, root_in;
   bar_side_type             side_ff;

   generate
      if (STEP < CORDIC_STEPS) begin : g_cordic
         localparam logic [31:0] ANGLE = ATAN_TURNS[STEP];
         logic signed [CORD_W-1:0] xs;
         logic signed [CORD_W-1:0] ys;
         assign xs = up_x >>> STEP;
         assign ys = up_y >>> STEP;
         // y >= 0 rotates clockwise
         always_comb begin
            if (!up_y[CORD_W-1]) begin
               x_in   = up_x + ys;
               y_in   = up_y - xs;
               acc_in = up_acc + ANGLE;
            end else begin
               x_in   = up_x - ys;
               y_in   = up_y + xs;
               acc_in = up_acc - ANGLE;
            end
         end
      end else begin : g_cordic_pass
         assign x_in   = up_x;
         assign y_in   = up_y;
         assign acc_in = up_acc;
      end

      if (STEP < ROOT_W) begin : g_sqrt
         logic [REM_W-1:0] rem_cat;
         logic [REM_W-1:0] trial;
         logic             ge;
         // top two bits of rem are zero here, room for the next digit pair
         assign rem_cat = {up_rem[REM_W-3:0], up_rad[RAD_W-1 -: 2]};
         assign trial   = {up_root, 2'b01};
         assign ge      = (rem_cat >= trial);
         assign rem_in  = ge ? (rem_cat - trial) : rem_cat;
         assign root_in = {up_root[ROOT_W-2:0], ge};
         assign rad_in  = up_rad << 2;
      end else begin : g_sqrt_pass
         assign rem_in  = up_rem;
         assign root_in = up_root;
         assign rad_in  = up_rad;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         acc_ff  <= acc_in;
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_x     = x_ff;
   assign dn_y     = y_ff;
   assign dn_acc   = acc_ff;
   assign dn_rad   = rad_ff;
   assign dn_rem   = rem_ff;
   assign dn_root  = root_ff;
   assign dn_side  = side_ff;

endmodule

// File: src/bar_checker.sv
// ----------------------------------------------------------------------------
// bar_checker
// Port-level checks on the bearing unit: result handshake, request/result
// balance and skid behavior.
// ----------------------------------------------------------------------------
module bar_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_aligned,
   input logic [15:0] rsp_heading_error,
   input logic [15:0] rsp_distance_mm
);
   logic [7:0] pending_ff, pending_in;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_take) begin
         pending_in = pending_ff + 8'd1;
      end else if (rsp_take && !req_take) begin
         pending_in = pending_ff - 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_aligned) && $stable(rsp_heading_error)
                                  && $stable(rsp_distance_mm))
      else $error("result payload changed while stalled");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 8'd0)
      else $error("result without a pending request");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request side stalled with no result waiting");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind bearing_alignment_and_range_unit bar_checker u_bar_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_aligned       (rsp_ch.aligned),
   .rsp_heading_error (rsp_ch.heading_error),
   .rsp_distance_mm   (rsp_ch.distance_mm)
);
